// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segment tracker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property with a synchronous reset that disables it.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Same-cycle implication built on the general form.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

`endif

// File: rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// Segment tracker package
// Beat types, item mode codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam int SLOT_BITS  = 10;
   localparam int COUNT_BITS = 11;
   localparam int FIELD_BITS = 32;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef logic [2:0] rsp_kind_type;

   localparam rsp_kind_type RSP_NONE  = 3'd0;
   localparam rsp_kind_type RSP_LOAD  = 3'd1;
   localparam rsp_kind_type RSP_FULL  = 3'd2;
   localparam rsp_kind_type RSP_QUERY = 3'd3;
   localparam rsp_kind_type RSP_CLEAR = 3'd4;
   localparam rsp_kind_type RSP_OTHER = 3'd5;

   typedef struct packed {
      logic [1:0]                   mode;
      logic signed [FIELD_BITS-1:0] x_start;
      logic signed [FIELD_BITS-1:0] y_start;
      logic signed [FIELD_BITS-1:0] x_end;
      logic signed [FIELD_BITS-1:0] y_end;
      logic [SLOT_BITS-1:0]         query_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  slot;
      logic                  is_top;
      logic [COUNT_BITS-1:0] covered_now;
      logic [COUNT_BITS-1:0] stored_count;
      logic                  table_full;
      logic                  slot_valid;
   } rsp_type;

   typedef struct packed {
      logic         latch;
      logic         scan_issue;
      logic         query_issue;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic [1:0] in_mode;
      logic [1:0] held_mode;
      logic       table_full;
      logic       count_zero;
      logic       scan_last;
      logic       pipe_empty;
   } status_type;

endpackage

// File: rtl/tst_ctrl.sv
// ----------------------------------------------------------------------------
// Segment tracker controller
// Sequences load scans, queries and replies through the datapath.
// ----------------------------------------------------------------------------
module tst_ctrl
   import tst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_QREAD  = 3'd4;
   localparam logic [2:0] ST_QRESP  = 3'd5;
   localparam logic [2:0] ST_REPLY  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               priority if (status.in_mode == MODE_LOAD && !status.table_full &&
                            !status.count_zero) begin
                  state_in = ST_SCAN;
               end else if (status.in_mode == MODE_LOAD && !status.table_full) begin
                  state_in = ST_DRAIN;
               end else if (status.in_mode == MODE_QUERY) begin
                  state_in = ST_QREAD;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait until every mark update from the compare pipeline has landed.
            if (status.pipe_empty) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.rsp_kind = RSP_LOAD;
            state_in     = ST_IDLE;
         end
         ST_QREAD: begin
            cmd.query_issue = 1'b1;
            state_in        = ST_QRESP;
         end
         ST_QRESP: begin
            cmd.rsp_kind = RSP_QUERY;
            state_in     = ST_IDLE;
         end
         ST_REPLY: begin
            priority if (status.held_mode == MODE_LOAD) begin
               cmd.rsp_kind = RSP_FULL;
            end else if (status.held_mode == MODE_CLEAR) begin
               cmd.rsp_kind = RSP_CLEAR;
            end else begin
               cmd.rsp_kind = RSP_OTHER;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/tst_datapath.sv
// ----------------------------------------------------------------------------
// Segment tracker datapath
// Segment and mark memories, the four-stage intersection pipeline, counters
// and the result register.
// ----------------------------------------------------------------------------
module tst_datapath
   import tst_pkg::*;
#(
   parameter int MAX_SEGMENTS = 1024,
   parameter int COORD_BITS   = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_data
);

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int SW = 4 * COORD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DW-1:0]         diff_type;
   typedef logic signed [PW-1:0]         prod_type;

   function automatic diff_type diff(input coord_type a, input coord_type b);
      diff = DW'(a) - DW'(b);
   endfunction

   function automatic coord_type smin(input coord_type a, input coord_type b);
      smin = (a < b) ? a : b;
   endfunction

   function automatic coord_type smax(input coord_type a, input coord_type b);
      smax = (a > b) ? a : b;
   endfunction

   // Held item and counters.
   req_type       held_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] idx_ff;
   logic [CW-1:0] covered_ff;

   coord_type cx, cy, dx, dy;
   assign cx = held_ff.x_start[COORD_BITS-1:0];
   assign cy = held_ff.y_start[COORD_BITS-1:0];
   assign dx = held_ff.x_end[COORD_BITS-1:0];
   assign dy = held_ff.y_end[COORD_BITS-1:0];

   // Memories.
   logic [SW-1:0] seg_mem [MAX_SEGMENTS];
   logic          mark_mem [MAX_SEGMENTS];
   logic [SW-1:0] seg_rd_ff;
   logic          mark_rd_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          commit;

   assign rd_en   = cmd.scan_issue | cmd.query_issue;
   assign rd_addr = cmd.scan_issue ? idx_ff : AW'(held_ff.query_slot);
   assign commit  = (cmd.rsp_kind == RSP_LOAD);

   // Pipeline registers.
   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AW-1:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic          keep2_ff, keep3_ff, hit4_ff;
   diff_type      e2_ff [12];
   prod_type      p3_ff [8];

   always_ff @(posedge clock) begin
      if (commit) begin
         seg_mem[count_ff[AW-1:0]] <= {cx, cy, dx, dy};
      end
      if (rd_en) begin
         seg_rd_ff <= seg_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         mark_mem[count_ff[AW-1:0]] <= 1'b1;
      end else if (v4_ff && hit4_ff) begin
         mark_mem[idx4_ff] <= 1'b0;
      end
      if (rd_en) begin
         mark_rd_ff <= mark_mem[rd_addr];
      end
   end

   // Stage one: differences and bounding box test on the stored segment.
   coord_type ax, ay, bx, by;
   diff_type  e1 [12];
   logic      box_ok;

   assign ax = seg_rd_ff[SW-1 -: COORD_BITS];
   assign ay = seg_rd_ff[3*COORD_BITS-1 -: COORD_BITS];
   assign bx = seg_rd_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign by = seg_rd_ff[COORD_BITS-1:0];

   always_comb begin
      e1[0]  = diff(cx, ax);
      e1[1]  = diff(cy, ay);
      e1[2]  = diff(bx, ax);
      e1[3]  = diff(by, ay);
      e1[4]  = diff(dx, ax);
      e1[5]  = diff(dy, ay);
      e1[6]  = diff(ax, cx);
      e1[7]  = diff(ay, cy);
      e1[8]  = diff(dx, cx);
      e1[9]  = diff(dy, cy);
      e1[10] = diff(bx, cx);
      e1[11] = diff(by, cy);
      box_ok = !(smax(ax, bx) < smin(cx, dx) || smin(ax, bx) > smax(cx, dx) ||
                 smax(ay, by) < smin(cy, dy) || smin(ay, by) > smax(cy, dy));
   end

   // Stage two: the eight cross-product terms.
   prod_type p2 [8];

   always_comb begin
      p2[0] = e2_ff[0]  * e2_ff[3];
      p2[1] = e2_ff[2]  * e2_ff[1];
      p2[2] = e2_ff[2]  * e2_ff[5];
      p2[3] = e2_ff[4]  * e2_ff[3];
      p2[4] = e2_ff[6]  * e2_ff[9];
      p2[5] = e2_ff[8]  * e2_ff[7];
      p2[6] = e2_ff[8]  * e2_ff[11];
      p2[7] = e2_ff[10] * e2_ff[9];
   end

   // Stage three: cross-product signs and the straddle tests.
   logic [3:0] pos3, neg3;
   logic       hit3;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pos3[k] = p3_ff[2*k] > p3_ff[2*k+1];
         neg3[k] = p3_ff[2*k] < p3_ff[2*k+1];
      end
      hit3 = keep3_ff &&
             !((pos3[0] && neg3[1]) || (neg3[0] && pos3[1])) &&
             !((pos3[2] && neg3[3]) || (neg3[2] && pos3[3]));
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= rd_addr;
      idx2_ff  <= idx1_ff;
      keep2_ff <= mark_rd_ff && box_ok;
      e2_ff    <= e1;
      idx3_ff  <= idx2_ff;
      keep3_ff <= keep2_ff;
      p3_ff    <= p2;
      idx4_ff  <= idx3_ff;
      hit4_ff  <= hit3;
      if (cmd.latch) begin
         held_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         count_ff   <= '0;
         idx_ff     <= '0;
         covered_ff <= '0;
      end else begin
         v1_ff <= cmd.scan_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (cmd.latch) begin
            idx_ff <= '0;
         end else if (cmd.scan_issue) begin
            idx_ff <= idx_ff + AW'(1);
         end
         if (cmd.latch) begin
            covered_ff <= '0;
         end else if (v4_ff && hit4_ff) begin
            covered_ff <= covered_ff + CW'(1);
         end
         if (commit) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.rsp_kind == RSP_CLEAR) begin
            count_ff <= '0;
         end
      end
   end

   // Result register.
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_strobe_ff;
   logic    q_valid;

   assign q_valid = 32'(held_ff.query_slot) < 32'(count_ff);

   always_comb begin
      rsp_in = '0;
      unique case (cmd.rsp_kind)
         RSP_LOAD: begin
            rsp_in.slot         = SLOT_BITS'(count_ff);
            rsp_in.covered_now  = COUNT_BITS'(covered_ff);
            rsp_in.stored_count = COUNT_BITS'(count_ff + CW'(1));
         end
         RSP_FULL: begin
            rsp_in.table_full   = 1'b1;
            rsp_in.stored_count = COUNT_BITS'(count_ff);
         end
         RSP_QUERY: begin
            rsp_in.slot         = held_ff.query_slot;
            rsp_in.slot_valid   = q_valid;
            rsp_in.is_top       = q_valid && mark_rd_ff;
            rsp_in.stored_count = COUNT_BITS'(count_ff);
         end
         RSP_OTHER: begin
            rsp_in.stored_count = COUNT_BITS'(count_ff);
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_kind != RSP_NONE) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cmd.rsp_kind != RSP_NONE);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign status.in_mode    = req_data.mode;
   assign status.held_mode  = held_ff.mode;
   assign status.table_full = (count_ff == CW'(MAX_SEGMENTS));
   assign status.count_zero = (count_ff == '0);
   assign status.scan_last  = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign status.pipe_empty = !(v1_ff || v2_ff || v3_ff || v4_ff);

endmodule

// File: rtl/top_segment_tracker.sv
// ----------------------------------------------------------------------------
// Segment tracker top level
// Table of line segments with a top mark each, intersection tested on load.
// ----------------------------------------------------------------------------
// Usage:
//   An item beat on req_data is taken at a rising edge with start high and
//   busy low. Mode load stores a segment and clears the top mark of every
//   stored segment it intersects, mode query reads one slot's top mark, and
//   mode clear empties the table.
//   Exactly one result beat follows each item on rsp_data, marked by
//   rsp_strobe for a single cycle. The receiver cannot stall; every result
//   is taken in the cycle it is shown.
//   A load scans the stored segments through the segment memory read port,
//   one stored segment per cycle into a four-stage compare pipeline, then
//   waits for the pipeline to drain; a load into an empty table goes straight
//   to the drain, and a load on a full table is dropped. One item is in work
//   at a time; busy stays high until its result is formed, and the next item
//   may be started during the strobe cycle.
//   Reset empties the table and returns the block to idle. No clearing
//   pass is needed; memory contents at or above the stored count never reach a result.
// ----------------------------------------------------------------------------
module top_segment_tracker
   import tst_pkg::*;
#(
   parameter int MAX_SEGMENTS = 1024,
   parameter int COORD_BITS   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   tst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   tst_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/tst_checker.sv
// ----------------------------------------------------------------------------
// Segment tracker checker
// Port-level assertions on the item and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tst_checker
   import tst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic accept;
   logic full_beat;
   logic full_clean;
   logic top_beat;

   assign accept     = start && !busy;
   assign full_beat  = rsp_strobe && rsp_data.table_full;
   assign full_clean = (rsp_data.covered_now == '0) && !rsp_data.slot_valid &&
                       (rsp_data.slot == '0);
   assign top_beat   = rsp_strobe && rsp_data.is_top;

   // An accepted beat always puts the block to work.
   `ASSERT_CLK(a_accept_busy, clock, reset, accept |=> busy, "accept did not raise busy")

   // A result is formed only while an item is in work.
   `ASSERT_IMPL(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy), "strobe without item")

   // Results never come on consecutive cycles.
   `ASSERT_CLK(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe, "strobe on two cycles")

   // A dropped load reports no slot and no covered segments.
   `ASSERT_IMPL(a_full_fields, clock, reset, full_beat, full_clean, "full result fields set")

   // A top mark is reported only for a slot inside the table.
   `ASSERT_IMPL(a_top_valid, clock, reset, top_beat, rsp_data.slot_valid, "top mark on bad slot")

endmodule

bind top_segment_tracker tst_checker u_tst_checker (.*);

// File: dv/top_segment_tracker_test.sv
// ----------------------------------------------------------------------------
// Segment tracker testbench
// Sends load, query, clear and unused-mode items to the tracker. A scripted
// opening covers the special cases, a random part follows, and a last phase
// stacks segments and crosses them all with one load. Every result beat is
// checked field by field against a scripted result or the behavioral table copy.
// ----------------------------------------------------------------------------
module top_segment_tracker_test;
   import tst_pkg::*;

   localparam int TABLE_DEPTH  = 1024;
   localparam int STACK_DEPTH  = 40;
   localparam int ONE          = 65536;
   localparam int C_MIN        = 32'sh8000_0000;
   localparam int C_MAX        = 32'sh7fff_ffff;
   localparam int RANDOM_ITEMS = 500;
   localparam int TAIL_CYCLES  = TABLE_DEPTH + 16;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef logic signed [33:0] coord_type;
   typedef logic signed [67:0] wide_type;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Behavioral copy of the segment table.
   coord_type seg_ax [TABLE_DEPTH];
   coord_type seg_ay [TABLE_DEPTH];
   coord_type seg_bx [TABLE_DEPTH];
   coord_type seg_by [TABLE_DEPTH];
   bit        top_mark [TABLE_DEPTH];
   int        seg_count = 0;

   rsp_type        pending_outcomes[$];
   script_row_type script_rows[$];
   bit             failed = 1'b0;
   int             burst_left = 0;

   top_segment_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic coord_type lo2(input coord_type a, input coord_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic coord_type hi2(input coord_type a, input coord_type b);
      return (a > b) ? a : b;
   endfunction

   // Sign of px*qy - qx*py, computed exactly at full width.
   function automatic int cross_sign(input coord_type px, input coord_type py,
                                     input coord_type qx, input coord_type qy);
      wide_type lhs, rhs;
      lhs = wide_type'(px) * wide_type'(qy);
      rhs = wide_type'(qx) * wide_type'(py);
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
   endfunction

   function automatic bit segments_meet(input int i, input coord_type cx, input coord_type cy,
                                        input coord_type dx, input coord_type dy);
      coord_type ax, ay, bx, by;
      int        s1, s2, s3, s4;
      ax = seg_ax[i];
      ay = seg_ay[i];
      bx = seg_bx[i];
      by = seg_by[i];
      if (hi2(ax, bx) < lo2(cx, dx) || lo2(ax, bx) > hi2(cx, dx) ||
          hi2(ay, by) < lo2(cy, dy) || lo2(ay, by) > hi2(cy, dy))
         return 1'b0;
      s1 = cross_sign(cx - ax, cy - ay, bx - ax, by - ay);
      s2 = cross_sign(bx - ax, by - ay, dx - ax, dy - ay);
      s3 = cross_sign(ax - cx, ay - cy, dx - cx, dy - cy);
      s4 = cross_sign(dx - cx, dy - cy, bx - cx, by - cy);
      return (s1 * s2 >= 0) && (s3 * s4 >= 0);
   endfunction

   // Applies one item to the table copy and returns the result it must give.
   function automatic rsp_type table_outcome(input req_type item);
      rsp_type   r;
      coord_type cx, cy, dx, dy;
      r  = '0;
      cx = coord_type'($signed(item.x_start));
      cy = coord_type'($signed(item.y_start));
      dx = coord_type'($signed(item.x_end));
      dy = coord_type'($signed(item.y_end));
      case (item.mode)
         MODE_LOAD: begin
            if (seg_count >= TABLE_DEPTH) begin
               r.table_full = 1'b1;
            end else begin
               for (int i = 0; i < seg_count; i++) begin
                  if (top_mark[i] && segments_meet(i, cx, cy, dx, dy)) begin
                     top_mark[i]   = 1'b0;
                     r.covered_now = r.covered_now + 1'b1;
                  end
               end
               seg_ax[seg_count]   = cx;
               seg_ay[seg_count]   = cy;
               seg_bx[seg_count]   = dx;
               seg_by[seg_count]   = dy;
               top_mark[seg_count] = 1'b1;
               r.slot = SLOT_BITS'(seg_count);
               seg_count++;
            end
         end
         MODE_QUERY: begin
            r.slot = item.query_slot;
            if (int'(item.query_slot) < seg_count) begin
               r.slot_valid = 1'b1;
               r.is_top     = top_mark[item.query_slot];
            end
         end
         MODE_CLEAR: seg_count = 0;
         default: ;
      endcase
      r.stored_count = COUNT_BITS'(seg_count);
      return r;
   endfunction

   function automatic rsp_type outcome(input int slot, input int is_top, input int covered,
                                       input int count, input int full, input int valid);
      rsp_type r;
      r.slot         = SLOT_BITS'(slot);
      r.is_top       = is_top[0];
      r.covered_now  = COUNT_BITS'(covered);
      r.stored_count = COUNT_BITS'(count);
      r.table_full   = full[0];
      r.slot_valid   = valid[0];
      return r;
   endfunction

   function automatic script_row_type row(input logic [1:0] mode, input int xs, input int ys,
                                          input int xe, input int ye, input int qslot,
                                          input bit typed = 1'b0, input rsp_type want = '0);
      script_row_type r;
      r.item.mode       = mode;
      r.item.x_start    = xs;
      r.item.y_start    = ys;
      r.item.x_end      = xe;
      r.item.y_end      = ye;
      r.item.query_slot = SLOT_BITS'(qslot);
      r.typed           = typed;
      r.want            = want;
      return r;
   endfunction

   function automatic void add_row(input script_row_type r);
      script_rows = {script_rows, r};
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run of back-to-back beats.
   function automatic int idle_cycles();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A small grid keeps crossings, touches and collinear overlaps frequent.
   function automatic int pick_coord();
      int v;
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1: v = ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
         default: begin
            v = (int'($urandom_range(0, 8)) - 4) * ONE;
            if ($urandom_range(0, 3) == 0) v += int'($urandom_range(0, ONE - 1));
         end
      endcase
      return v;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      pick, j;
      item.x_start    = $urandom;
      item.y_start    = $urandom;
      item.x_end      = $urandom;
      item.y_end      = $urandom;
      item.query_slot = SLOT_BITS'($urandom_range(0, TABLE_DEPTH - 1));
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         item.mode = MODE_LOAD;
         pick = $urandom_range(0, 9);
         if (pick != 0) begin
            item.x_start = pick_coord();
            item.y_start = pick_coord();
            item.x_end   = pick_coord();
            item.y_end   = pick_coord();
            if (pick < 3 && seg_count > 0) begin
               // Start on an endpoint of a stored segment.
               j = $urandom_range(0, seg_count - 1);
               item.x_start = seg_bx[j][31:0];
               item.y_start = seg_by[j][31:0];
            end else if (pick == 3) begin
               item.y_end = item.y_start;
            end else if (pick == 4) begin
               item.x_end = item.x_start;
            end
         end
      end else if (pick < 86) begin
         item.mode = MODE_QUERY;
         if (seg_count > 0 && $urandom_range(0, 3) != 0)
            item.query_slot = SLOT_BITS'($urandom_range(0, seg_count - 1));
      end else if (pick < 92) begin
         item.mode = MODE_UNUSED;
      end else begin
         item.mode = MODE_CLEAR;
      end
      return item;
   endfunction

   // Holds the beat until it is taken, records its expected result, then idles.
   // With settle set, the sender also waits until every result is back.
   task automatic send_item(input req_type item, input bit typed, input rsp_type want,
                            input bit settle);
      rsp_type predicted;
      int      gap;
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = table_outcome(item);
      pending_outcomes = {pending_outcomes, (typed ? want : predicted)};
      gap = idle_cycles();
      if (settle || gap > 0) begin
         start <= 1'b0;
         while (settle && pending_outcomes.size() != 0) @(posedge clock);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failed = 1'b1;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            $error("result beat with no item outstanding");
            failed = 1'b1;
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("slot", want.slot, rsp_data.slot);
            compare_field("is_top", want.is_top, rsp_data.is_top);
            compare_field("covered_now", want.covered_now, rsp_data.covered_now);
            compare_field("stored_count", want.stored_count, rsp_data.stored_count);
            compare_field("table_full", want.table_full, rsp_data.table_full);
            compare_field("slot_valid", want.slot_valid, rsp_data.slot_valid);
         end
      end
   end

   initial begin : stimulus
      req_type item;
      rsp_type blank;
      int      clear_at;
      blank = '0;

      // Empty table: queries, unused mode and clear.
      add_row(row(MODE_QUERY, 0, 0, 0, 0, 0, 1'b1, outcome(0, 0, 0, 0, 0, 0)));
      add_row(row(MODE_UNUSED, 0, 0, 0, 0, 0, 1'b1, outcome(0, 0, 0, 0, 0, 0)));
      add_row(row(MODE_CLEAR, 0, 0, 0, 0, 0, 1'b1, outcome(0, 0, 0, 0, 0, 0)));
      add_row(row(MODE_QUERY, 0, 0, 0, 0, TABLE_DEPTH - 1, 1'b1,
                  outcome(TABLE_DEPTH - 1, 0, 0, 0, 0, 0)));
      // A plain crossing: the second segment takes the first one's top mark.
      add_row(row(MODE_LOAD, 0, 0, 10 * ONE, 0, 0, 1'b1,
                  outcome(0, 0, 0, 1, 0, 0)));
      add_row(row(MODE_LOAD, 5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, 0, 1'b1,
                  outcome(1, 0, 1, 2, 0, 0)));
      add_row(row(MODE_QUERY, 0, 0, 0, 0, 0, 1'b1, outcome(0, 0, 0, 2, 0, 1)));
      add_row(row(MODE_QUERY, 0, 0, 0, 0, 1, 1'b1, outcome(1, 1, 0, 2, 0, 1)));
      // Collinear segments touching end to end, then collinear but apart.
      add_row(row(MODE_LOAD, 0, 10 * ONE, 10 * ONE, 10 * ONE, 0));
      add_row(row(MODE_LOAD, 10 * ONE, 10 * ONE, 20 * ONE, 10 * ONE, 0));
      add_row(row(MODE_LOAD, 30 * ONE, 10 * ONE, 40 * ONE, 10 * ONE, 0));
      // An endpoint landing on the inside of a stored segment.
      add_row(row(MODE_LOAD, 15 * ONE, 10 * ONE, 15 * ONE, 20 * ONE, 0));
      add_row(row(MODE_LOAD, 0, -ONE, 10 * ONE, -ONE, 0));
      // Full-range diagonals push the cross products to their widest.
      add_row(row(MODE_LOAD, C_MIN, C_MIN, C_MAX, C_MAX, 0));
      add_row(row(MODE_LOAD, C_MAX, C_MIN, C_MIN, C_MAX, 0));
      // A segment of zero length at the origin.
      add_row(row(MODE_LOAD, 0, 0, 0, 0, 0));
      // Bounding boxes overlap but the segments do not cross.
      add_row(row(MODE_LOAD, 6 * ONE, 2 * ONE, 9 * ONE, 8 * ONE, 0));
      add_row(row(MODE_QUERY, 0, 0, 0, 0, TABLE_DEPTH - 1));
      add_row(row(MODE_UNUSED, C_MAX, C_MIN, C_MAX, C_MIN, 7));
      add_row(row(MODE_QUERY, 0, 0, 0, 0, 3));
      add_row(row(MODE_CLEAR, 0, 0, 0, 0, 0, 1'b1, outcome(0, 0, 0, 0, 0, 0)));
      add_row(row(MODE_QUERY, 0, 0, 0, 0, 0, 1'b1, outcome(0, 0, 0, 0, 0, 0)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[i])
         send_item(script_rows[i].item, script_rows[i].typed, script_rows[i].want,
                   i == script_rows.size() - 1);

      // Random items on a table that is emptied before it grows large.
      clear_at = $urandom_range(4, 48);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_count >= clear_at) begin
            item      = random_item();
            item.mode = MODE_CLEAR;
            clear_at  = $urandom_range(4, 48);
         end else begin
            item = random_item();
         end
         send_item(item, 1'b0, blank, $urandom_range(0, 59) == 0);
      end

      // Stack horizontal segments that never meet.
      item      = random_item();
      item.mode = MODE_CLEAR;
      send_item(item, 1'b1, outcome(0, 0, 0, 0, 0, 0), 1'b1);
      for (int n = 0; n < STACK_DEPTH; n++) begin
         item.mode    = MODE_LOAD;
         item.x_start = int'($urandom_range(0, 40)) * ONE;
         item.y_start = n * ONE;
         item.x_end   = int'($urandom_range(60, 100)) * ONE;
         item.y_end   = n * ONE;
         send_item(item, 1'b0, blank, 1'b0);
      end
      // A vertical segment that crosses every stored one.
      item.x_start = 50 * ONE;
      item.y_start = -ONE;
      item.x_end   = 50 * ONE;
      item.y_end   = (STACK_DEPTH + 10) * ONE;
      send_item(item, 1'b1,
                outcome(STACK_DEPTH, 0, STACK_DEPTH, STACK_DEPTH + 1, 0, 0), 1'b0);
      item.mode       = MODE_QUERY;
      item.query_slot = '0;
      send_item(item, 1'b1, outcome(0, 0, 0, STACK_DEPTH + 1, 0, 1), 1'b0);
      item.query_slot = SLOT_BITS'(STACK_DEPTH);
      send_item(item, 1'b1, outcome(STACK_DEPTH, 1, 0, STACK_DEPTH + 1, 0, 1), 1'b0);
      item.mode = MODE_UNUSED;
      send_item(item, 1'b1, outcome(0, 0, 0, STACK_DEPTH + 1, 0, 0), 1'b0);
      for (int n = 0; n < 6; n++) begin
         item.mode       = MODE_QUERY;
         item.query_slot = SLOT_BITS'($urandom_range(0, TABLE_DEPTH - 1));
         send_item(item, 1'b0, blank, 1'b0);
      end
      item.mode = MODE_CLEAR;
      send_item(item, 1'b1, outcome(0, 0, 0, 0, 0, 0), 1'b1);

      // Catch any stray result beat after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #60_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
